@@ src/krt_pkg.sv @@
// Shared types and codes for the keyed rule table.
// No dependencies; imported by the top level, krt_datapath and krt_ctrl.
package krt_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_UPDATE   = 4'd1,
    OP_DELETE   = 4'd2,
    OP_ENABLE   = 4'd3,
    OP_FIND_KEY = 4'd4,
    OP_FIND_FP  = 4'd5,
    OP_READ     = 4'd6,
    OP_LIST     = 4'd7,
    OP_CLEAR    = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_DUP      = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_RANGE    = 3'd4
  } st_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] fp;
    logic [7:0]  prio;
    logic [31:0] created;
    logic        en;
    logic [63:0] payload;
  } rule_t;

  typedef struct packed {
    logic [3:0] op;
    rule_t      rule;
    logic [3:0] slot;
  } item_t;

  typedef struct packed {
    st_t        status;
    rule_t      rule;
    logic [4:0] count;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {P_HOLD, P_ZERO, P_INC} p_op_t;
  typedef enum logic [1:0] {Q_HOLD, Q_FROM_P, Q_INC} q_op_t;
  typedef enum logic [2:0] {RD_NONE, RD_P, RD_P1, RD_SLOT, RD_ORD} rd_src_t;
  typedef enum logic {SEL_P, SEL_Q} sel_t;
  typedef enum logic {OW_P, OW_A} ow_t;
  typedef enum logic {WA_CNT, WA_P} wa_t;
  typedef enum logic [1:0] {WD_ITEM, WD_HIT_EN, WD_RDATA} wd_t;
  typedef enum logic [1:0] {C_HOLD, C_INC, C_DEC, C_ZERO} c_op_t;
  typedef enum logic [2:0] {RS_ZERO, RS_ITEM, RS_HIT, RS_HIT_EN, RS_RDATA} rs_t;

  typedef struct packed {
    logic    load;
    p_op_t   p_op;
    q_op_t   q_op;
    rd_src_t rd_src;
    logic    om_re;
    sel_t    om_rsel;
    logic    om_we;
    sel_t    om_wsel;
    ow_t     om_wdat;
    logic    rm_we;
    wa_t     rm_waddr;
    wd_t     rm_wdat;
    logic    hit_load;
    logic    a_load;
    c_op_t   cnt_op;
    logic    res_load;
    rs_t     res_src;
    st_t     res_st;
    logic    res_last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       full;
    logic       p_ge;
    logic       p1_ge;
    logic       q_ge;
    logic       match;
    logic       swap;
    logic       slot_oor;
    logic       empty;
    logic       out_busy;
  } sts_t;

endpackage

@@ src/krt_if.sv @@
// Request and response channel interfaces for the keyed rule table.
// Depends on nothing; payload fields follow the port list of the block.
interface krt_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  opcode;
  logic [63:0] rule_key;
  logic [63:0] rule_fingerprint;
  logic [7:0]  prio_level;
  logic [31:0] created_time;
  logic        enable_flag;
  logic [63:0] rule_payload;
  logic [3:0]  slot_index;
  modport source (output valid, opcode, rule_key, rule_fingerprint, prio_level,
                  created_time, enable_flag, rule_payload, slot_index, input ready);
  modport sink (input valid, opcode, rule_key, rule_fingerprint, prio_level,
                created_time, enable_flag, rule_payload, slot_index, output ready);
endinterface

interface krt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] out_key;
  logic [63:0] out_fprint;
  logic [7:0]  out_prio;
  logic [31:0] out_created;
  logic        out_enable;
  logic [63:0] out_payload;
  logic [4:0]  entry_count;
  logic        last_of_run;
  modport source (output valid, status, out_key, out_fprint, out_prio,
                  out_created, out_enable, out_payload, entry_count, last_of_run,
                  input ready);
  modport sink (input valid, status, out_key, out_fprint, out_prio,
                out_created, out_enable, out_payload, entry_count, last_of_run,
                output ready);
endinterface

@@ src/keyed_rule_table_with_priority_list.sv @@
// Keyed rule table with priority-ordered listing: top level.
// Uses krt_pkg, krt_if, krt_ctrl and krt_datapath.
//
// Usage: commands enter on req (valid/ready); each accepted word is one
// operation. Results leave on rsp; every operation returns one result word,
// a non-empty list returns one per held rule, last_of_run marks the final one.
// Sequencing: lookups, update, enable and add scan the rule memory one
// slot at a time; delete then moves each later slot down by one; read
// slot reads the named slot; clear, unknown opcodes, an add to a full
// table and an empty list go straight to their result word.
// List fills the order memory with one index per held rule, then runs
// the exchange sort in outer passes of compares, then emits one word per
// held rule, reading the rule memory through its single read port.
// One command is handled at a time; a new one is taken once the previous
// one has loaded its last result word.
// Reset (synchronous) empties the table and drops any pending result.
// When rsp stalls, the result word holds and the controller waits before
// loading the next one; a new command may be taken while the last word waits.
module keyed_rule_table_with_priority_list import krt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input logic      clk,
  input logic      rst,
  krt_req_if.sink  req,
  krt_rsp_if.source rsp
);

  cmd_t  cmd;
  sts_t  sts;
  item_t item_in;
  res_t  res;
  logic  accept;
  logic  ready;

  assign req.ready = ready;
  assign accept    = req.valid && ready;

  assign item_in.op           = req.opcode;
  assign item_in.rule.key     = req.rule_key;
  assign item_in.rule.fp      = req.rule_fingerprint;
  assign item_in.rule.prio    = req.prio_level;
  assign item_in.rule.created = req.created_time;
  assign item_in.rule.en      = req.enable_flag;
  assign item_in.rule.payload = req.rule_payload;
  assign item_in.slot         = req.slot_index;

  krt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sts    (sts),
    .ready  (ready),
    .cmd    (cmd)
  );

  krt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item_in   (item_in),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .rsp_valid (rsp.valid),
    .rsp_data  (res)
  );

  assign rsp.status      = res.status;
  assign rsp.out_key     = res.rule.key;
  assign rsp.out_fprint  = res.rule.fp;
  assign rsp.out_prio    = res.rule.prio;
  assign rsp.out_created = res.rule.created;
  assign rsp.out_enable  = res.rule.en;
  assign rsp.out_payload = res.rule.payload;
  assign rsp.entry_count = res.count;
  assign rsp.last_of_run = res.last;

endmodule

@@ src/krt_datapath.sv @@
// Datapath: rule memory, sort-order memory, pointers, count and result register.
// Depends on krt_pkg; driven by commands from krt_ctrl.
module krt_datapath import krt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  item_t item_in,
  input  logic  rsp_ready,
  output sts_t  sts,
  output logic  rsp_valid,
  output res_t  rsp_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  rule_t          rmem [TABLE_DEPTH];
  logic [IW-1:0]  omem [TABLE_DEPTH];

  item_t          item;
  rule_t          rdata;
  rule_t          hit;
  logic [IW-1:0]  ord_q;
  logic [IW-1:0]  a_idx;
  logic [7:0]     a_prio;
  logic [31:0]    a_time;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  p;
  logic [CW-1:0]  q;
  logic           res_valid;
  res_t           res;

  logic [CW:0]    p1;
  logic [IW-1:0]  raddr;
  logic [IW-1:0]  om_raddr;
  logic [IW-1:0]  om_waddr;
  logic [IW-1:0]  om_wdata;
  logic [IW-1:0]  rm_waddr;
  rule_t          rm_wdata;
  rule_t          hit_en;
  rule_t          res_rule;
  logic [CW+3:0]  slot_x;
  logic [CW+4:0]  cnt_x;
  logic           use_fp;

  assign p1     = {1'b0, p} + {{CW{1'b0}}, 1'b1};
  assign slot_x = {{CW{1'b0}}, item.slot};
  assign cnt_x  = {5'b0, cnt};
  assign use_fp = (item.op == OP_ADD) || (item.op == OP_FIND_FP);

  always_comb begin
    hit_en    = hit;
    hit_en.en = item.rule.en;
  end

  always_comb begin
    case (cmd.rd_src)
      RD_P1:   raddr = p1[IW-1:0];
      RD_SLOT: raddr = slot_x[IW-1:0];
      RD_ORD:  raddr = ord_q;
      default: raddr = p[IW-1:0];
    endcase
    om_raddr = (cmd.om_rsel == SEL_Q) ? q[IW-1:0] : p[IW-1:0];
    om_waddr = (cmd.om_wsel == SEL_Q) ? q[IW-1:0] : p[IW-1:0];
    om_wdata = (cmd.om_wdat == OW_A) ? a_idx : p[IW-1:0];
    rm_waddr = (cmd.rm_waddr == WA_CNT) ? cnt[IW-1:0] : p[IW-1:0];
    case (cmd.rm_wdat)
      WD_HIT_EN: rm_wdata = hit_en;
      WD_RDATA:  rm_wdata = rdata;
      default:   rm_wdata = item.rule;
    endcase
    case (cmd.res_src)
      RS_ITEM:   res_rule = item.rule;
      RS_HIT:    res_rule = hit;
      RS_HIT_EN: res_rule = hit_en;
      RS_RDATA:  res_rule = rdata;
      default:   res_rule = '0;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.rm_we) rmem[rm_waddr] <= rm_wdata;
    if (cmd.rd_src != RD_NONE) rdata <= rmem[raddr];
    if (cmd.om_we) omem[om_waddr] <= om_wdata;
    if (cmd.om_re) ord_q <= omem[om_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= item_in;
    if (cmd.hit_load) hit <= rdata;
    if (cmd.a_load) begin
      a_idx  <= ord_q;
      a_prio <= rdata.prio;
      a_time <= rdata.created;
    end
    if (cmd.res_load) begin
      res.status <= cmd.res_st;
      res.rule   <= res_rule;
      res.count  <= cnt_x[4:0];
      res.last   <= cmd.res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      p         <= '0;
      q         <= '0;
      res_valid <= 1'b0;
    end else begin
      case (cmd.cnt_op)
        C_INC:   cnt <= cnt + 1'b1;
        C_DEC:   cnt <= cnt - 1'b1;
        C_ZERO:  cnt <= '0;
        default: cnt <= cnt;
      endcase
      case (cmd.p_op)
        P_ZERO:  p <= '0;
        P_INC:   p <= p1[CW-1:0];
        default: p <= p;
      endcase
      case (cmd.q_op)
        Q_FROM_P: q <= p1[CW-1:0];
        Q_INC:    q <= q + 1'b1;
        default:  q <= q;
      endcase
      if (cmd.res_load) res_valid <= 1'b1;
      else if (rsp_ready) res_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.op       = item.op;
    sts.full     = (cnt >= CW'(TABLE_DEPTH));
    sts.p_ge     = (p >= cnt);
    sts.p1_ge    = (p1 >= {1'b0, cnt});
    sts.q_ge     = (q >= cnt);
    sts.match    = use_fp ? (rdata.fp == item.rule.fp) : (rdata.key == item.rule.key);
    sts.swap     = (rdata.prio > a_prio) ||
                   ((rdata.prio == a_prio) && (rdata.created > a_time));
    sts.slot_oor = ({1'b0, slot_x} >= cnt_x);
    sts.empty    = (cnt == '0);
    sts.out_busy = res_valid && !rsp_ready;
  end

  assign rsp_valid = res_valid;
  assign rsp_data  = res;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!res_valid || rsp_ready))
    else $error("result register overwritten before it was taken");
  a_add_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.rm_we && cmd.rm_waddr == WA_CNT) |-> !sts.full)
    else $error("append into a full table");
  a_inc_after_append: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_op == C_INC) |-> (cmd.rm_we && cmd.rm_waddr == WA_CNT))
    else $error("count raised without an append");
`endif

endmodule

@@ src/krt_ctrl.sv @@
// Controller: sequences scans, shifts, the exchange sort and result words.
// Depends on krt_pkg; commands krt_datapath and reads its status.
module krt_ctrl import krt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  sts_t sts,
  output logic ready,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SCAN_CHK, S_SCAN_RD, S_SCAN_CMP, S_FOUND, S_ADD_WR,
    S_DEL_CHK, S_DEL_RD, S_DEL_WR, S_SLOT_RD, S_SLOT_W,
    S_INIT, S_LO_RD, S_LO_W, S_LA_W, S_LQ_CHK, S_LQ_RD, S_LQ_W, S_LQ_CMP,
    S_LE_RD, S_LE_W, S_LE_RW, S_EMIT
  } state_t;

  state_t state, state_next;
  st_t    pend_st, pend_st_next;
  rs_t    pend_src, pend_src_next;

  assign ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd           = '0;
    cmd.load      = accept;
    state_next    = state;
    pend_st_next  = pend_st;
    pend_src_next = pend_src;
    unique case (state)
      S_IDLE: if (accept) state_next = S_DISPATCH;
      S_DISPATCH: begin
        cmd.p_op      = P_ZERO;
        pend_st_next  = ST_OK;
        pend_src_next = RS_ZERO;
        state_next    = S_EMIT;
        case (sts.op)
          OP_ADD: begin
            if (sts.full) pend_st_next = ST_FULL;
            else state_next = S_SCAN_CHK;
          end
          OP_UPDATE, OP_DELETE, OP_ENABLE, OP_FIND_KEY, OP_FIND_FP:
            state_next = S_SCAN_CHK;
          OP_READ: begin
            if (sts.slot_oor) pend_st_next = ST_RANGE;
            else state_next = S_SLOT_RD;
          end
          OP_LIST: begin
            if (sts.empty) pend_st_next = ST_NOTFOUND;
            else state_next = S_INIT;
          end
          OP_CLEAR: cmd.cnt_op = C_ZERO;
          default: ;
        endcase
      end
      S_SCAN_CHK: begin
        if (sts.p_ge) begin
          pend_src_next = RS_ZERO;
          pend_st_next  = ST_NOTFOUND;
          state_next    = (sts.op == OP_ADD) ? S_ADD_WR : S_EMIT;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd.rd_src = RD_P;
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          cmd.hit_load = 1'b1;
          state_next   = S_FOUND;
        end else begin
          cmd.p_op   = P_INC;
          state_next = S_SCAN_CHK;
        end
      end
      S_FOUND: begin
        pend_st_next  = ST_OK;
        pend_src_next = RS_HIT;
        state_next    = S_EMIT;
        case (sts.op)
          OP_ADD: pend_st_next = ST_DUP;
          OP_UPDATE: begin
            cmd.rm_we     = 1'b1;
            cmd.rm_waddr  = WA_P;
            cmd.rm_wdat   = WD_ITEM;
            pend_src_next = RS_ITEM;
          end
          OP_ENABLE: begin
            cmd.rm_we     = 1'b1;
            cmd.rm_waddr  = WA_P;
            cmd.rm_wdat   = WD_HIT_EN;
            pend_src_next = RS_HIT_EN;
          end
          OP_DELETE: state_next = S_DEL_CHK;
          default: ;
        endcase
      end
      S_ADD_WR: begin
        cmd.rm_we     = 1'b1;
        cmd.rm_waddr  = WA_CNT;
        cmd.rm_wdat   = WD_ITEM;
        cmd.cnt_op    = C_INC;
        pend_st_next  = ST_OK;
        pend_src_next = RS_ITEM;
        state_next    = S_EMIT;
      end
      // close the gap one entry at a time
      S_DEL_CHK: begin
        if (sts.p1_ge) begin
          cmd.cnt_op = C_DEC;
          state_next = S_EMIT;
        end else begin
          state_next = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        cmd.rd_src = RD_P1;
        state_next = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd.rm_we    = 1'b1;
        cmd.rm_waddr = WA_P;
        cmd.rm_wdat  = WD_RDATA;
        cmd.p_op     = P_INC;
        state_next   = S_DEL_CHK;
      end
      S_SLOT_RD: begin
        cmd.rd_src = RD_SLOT;
        state_next = S_SLOT_W;
      end
      S_SLOT_W: begin
        pend_src_next = RS_RDATA;
        state_next    = S_EMIT;
      end
      S_INIT: begin
        if (sts.p_ge) begin
          cmd.p_op   = P_ZERO;
          state_next = S_LO_RD;
        end else begin
          cmd.om_we   = 1'b1;
          cmd.om_wsel = SEL_P;
          cmd.om_wdat = OW_P;
          cmd.p_op    = P_INC;
        end
      end
      // outer pass: candidate for position p is held in the a registers
      S_LO_RD: begin
        cmd.om_re   = 1'b1;
        cmd.om_rsel = SEL_P;
        state_next  = S_LO_W;
      end
      S_LO_W: begin
        cmd.rd_src = RD_ORD;
        state_next = S_LA_W;
      end
      S_LA_W: begin
        cmd.a_load = 1'b1;
        cmd.q_op   = Q_FROM_P;
        state_next = S_LQ_CHK;
      end
      S_LQ_CHK: begin
        if (sts.q_ge) begin
          cmd.om_we   = 1'b1;
          cmd.om_wsel = SEL_P;
          cmd.om_wdat = OW_A;
          if (sts.p1_ge) begin
            cmd.p_op   = P_ZERO;
            state_next = S_LE_RD;
          end else begin
            cmd.p_op   = P_INC;
            state_next = S_LO_RD;
          end
        end else begin
          state_next = S_LQ_RD;
        end
      end
      S_LQ_RD: begin
        cmd.om_re   = 1'b1;
        cmd.om_rsel = SEL_Q;
        state_next  = S_LQ_W;
      end
      S_LQ_W: begin
        cmd.rd_src = RD_ORD;
        state_next = S_LQ_CMP;
      end
      S_LQ_CMP: begin
        if (sts.swap) begin
          cmd.om_we   = 1'b1;
          cmd.om_wsel = SEL_Q;
          cmd.om_wdat = OW_A;
          cmd.a_load  = 1'b1;
        end
        cmd.q_op   = Q_INC;
        state_next = S_LQ_CHK;
      end
      S_LE_RD: begin
        cmd.om_re   = 1'b1;
        cmd.om_rsel = SEL_P;
        state_next  = S_LE_W;
      end
      S_LE_W: begin
        cmd.rd_src = RD_ORD;
        state_next = S_LE_RW;
      end
      S_LE_RW: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = RS_RDATA;
          cmd.res_st   = ST_OK;
          cmd.res_last = sts.p1_ge;
          cmd.p_op     = P_INC;
          state_next   = sts.p1_ge ? S_IDLE : S_LE_RD;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          cmd.res_src  = pend_src;
          cmd.res_st   = pend_st;
          cmd.res_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pend_st  <= ST_OK;
      pend_src <= RS_ZERO;
    end else begin
      state    <= state_next;
      pend_st  <= pend_st_next;
      pend_src <= pend_src_next;
    end
  end

`ifndef SYNTHESIS
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_DISPATCH))
    else $error("accepted word not dispatched");
  a_emit_then_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.res_load && cmd.res_last) |=> (state == S_IDLE))
    else $error("final result not followed by idle");
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rm_we && cmd.om_we))
    else $error("rule and order memories written together");
`endif

endmodule
